FILE: rtl/cca_pkg.sv
// Shared types and constants of the CSMA/CA transmit/receive controller.
package cca_pkg;

  localparam int VALUE_W = 24;
  localparam int ACT_W   = 3;
  localparam int SLOT_IN_W = 3;
  localparam int PORT_W  = 2;
  localparam int CNT_W   = 12;
  localparam int REM_W   = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int TICK_W  = 10;
  localparam int SLOT_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;
  localparam int DUR_MOD = 1000;

  // Reciprocal of 1000 scaled by 2**41; exact floor for any value below 2**32.
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;

  localparam logic [ACT_W-1:0] ACT_TICK = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DATA = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RECV = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FREE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BUSY = 3'd4;

  localparam logic [PORT_W-1:0] PORT_SEND = 2'd0;
  localparam logic [PORT_W-1:0] PORT_SENT = 2'd1;
  localparam logic [PORT_W-1:0] PORT_DONE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_DIFS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIFS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOT = 2'd3;

  localparam logic [TICK_W-1:0] DIFS_RST = 10'd50;
  localparam logic [TICK_W-1:0] SIFS_RST = 10'd20;
  localparam logic [TICK_W-1:0] ACK_RST  = 10'd10;
  localparam logic [SLOT_W-1:0] SLOT_RST = 8'd5;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_WAIT_FREE = 4'd1,
    MODE_DIFS      = 4'd2,
    MODE_TRANSMIT  = 4'd3,
    MODE_WAIT_ACK  = 4'd4,
    MODE_ACK_RCVD  = 4'd5,
    MODE_RECEIVING = 4'd6,
    MODE_SIFS      = 4'd7,
    MODE_SEND_ACK  = 4'd8
  } mode_t;

  typedef struct packed {
    logic [TICK_W-1:0] difs;
    logic [TICK_W-1:0] sifs;
    logic [TICK_W-1:0] ack;
    logic [SLOT_W-1:0] slot;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ACT_W-1:0] action;
  } stage_ctrl_t;

endpackage

FILE: rtl/csma_ca_txrx_controller.sv
// Top level of the CSMA/CA transmit/receive controller.
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   action, msg_value, backoff_slots
//  result    out        out_valid / out_stall out_port, out_value
//  config    in         cfg_wr (no wait)      cfg_addr, cfg_wdata
//
// Each input transaction is accepted when in_stall is low; a new one can be
// accepted every cycle while the input is not stalled. The result register is
// reached through an input register, a stage for the reciprocal multiply by
// 1/1000, a stage for the remainder and backoff product, then the mode state
// machine, which updates all controller state and loads the result register.
// Reset is synchronous and active high; it restores the register defaults
// and leaves the controller idle with the channel marked free.
// A stalled result holds the result register and the state machine; the
// pipeline in front keeps filling, so input is stalled only once all three
// front stages are full.
//
// The controller models a CSMA/CA station: data waits DIFS plus a backoff,
// is sent for a duration taken from the low three decimal digits of its
// value, and is then reported as sent while an ack is awaited. A frame
// received while idle or in DIFS is timed, followed by SIFS and an ack whose
// value is the ack time plus the thousands part of the received frame.
module csma_ca_txrx_controller
  import cca_pkg::*;
#(
  parameter int MSG_WIDTH     = 24,
  parameter int BACKOFF_SLOTS = 5
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACT_W-1:0]      action,
  input  logic [VALUE_W-1:0]    msg_value,
  input  logic [SLOT_IN_W-1:0]  backoff_slots,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PORT_W-1:0]     out_port,
  output logic [VALUE_W-1:0]    out_value,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Backoff product width: slot index bits plus slot length bits.
  localparam int BOFF_W = $clog2(BACKOFF_SLOTS) + SLOT_W;

  cfg_t                 cfg;
  stage_ctrl_t          ctrl;
  logic                 take;
  logic [MSG_WIDTH-1:0] item_value;
  logic [REM_W-1:0]     item_rem;
  logic [MSG_WIDTH-1:0] item_thou;
  logic [BOFF_W-1:0]    item_boff;

  cca_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Front stages depend only on the incoming transaction and the slot length,
  // so they run ahead of the state machine without affecting its state loop.
  cca_front #(
    .MSG_WIDTH     (MSG_WIDTH),
    .BACKOFF_SLOTS (BACKOFF_SLOTS),
    .BOFF_W        (BOFF_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .msg_value     (msg_value),
    .backoff_slots (backoff_slots),
    .slot_ticks    (cfg.slot),
    .take          (take),
    .ctrl          (ctrl),
    .item_value    (item_value),
    .item_rem      (item_rem),
    .item_thou     (item_thou),
    .item_boff     (item_boff)
  );

  cca_core #(
    .MSG_WIDTH (MSG_WIDTH),
    .BOFF_W    (BOFF_W)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .item_value (item_value),
    .item_rem   (item_rem),
    .item_thou  (item_thou),
    .item_boff  (item_boff),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_port   (out_port),
    .out_value  (out_value)
  );

endmodule

FILE: rtl/cca_regs.sv
// Configuration register file of the CSMA/CA controller.
module cca_regs
  import cca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.difs <= DIFS_RST;
      cfg.sifs <= SIFS_RST;
      cfg.ack  <= ACK_RST;
      cfg.slot <= SLOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        CFG_DIFS: cfg.difs <= cfg_wdata;
        CFG_SIFS: cfg.sifs <= cfg_wdata;
        CFG_ACK:  cfg.ack  <= cfg_wdata;
        CFG_SLOT: cfg.slot <= cfg_wdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/cca_front.sv
// Input pipeline: captures transactions and derives duration, thousands and backoff.
module cca_front
  import cca_pkg::*;
#(
  parameter int MSG_WIDTH     = 24,
  parameter int BACKOFF_SLOTS = 5,
  parameter int BOFF_W        = $clog2(BACKOFF_SLOTS) + SLOT_W
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     action,
  input  logic [VALUE_W-1:0]   msg_value,
  input  logic [SLOT_IN_W-1:0] backoff_slots,
  input  logic [SLOT_W-1:0]    slot_ticks,
  input  logic                 take,
  output stage_ctrl_t          ctrl,
  output logic [MSG_WIDTH-1:0] item_value,
  output logic [REM_W-1:0]     item_rem,
  output logic [MSG_WIDTH-1:0] item_thou,
  output logic [BOFF_W-1:0]    item_boff
);

  localparam int SW = $clog2(BACKOFF_SLOTS);
  localparam int QW = MSG_WIDTH - 9;
  localparam int PW = MSG_WIDTH + 32;

  logic v0, v1, v2;
  logic adv0, adv1, accept;

  logic [ACT_W-1:0]     act0, act1, act2;
  logic [MSG_WIDTH-1:0] val0, val1, val2;
  logic [SLOT_IN_W-1:0] slots0;
  logic [SW-1:0]        smod1;
  logic [QW-1:0]        q1;
  logic [REM_W-1:0]     rem2;
  logic [MSG_WIDTH-1:0] thou2;
  logic [BOFF_W-1:0]    boff2;

  logic [PW-1:0]        prod;
  logic [5:0]           smod_c;
  logic [MSG_WIDTH-1:0] thou_c;
  logic [MSG_WIDTH-1:0] rem_c;

  assign adv1     = v1 && (!v2 || take);
  assign adv0     = v0 && (!v1 || adv1);
  assign in_stall = v0 && !adv0;
  assign accept   = in_valid && !in_stall;

  // Slot count reduced modulo the slot range by repeated subtraction.
  always_comb begin
    smod_c = 6'(slots0);
    for (int i = 0; i < 4; i++) begin
      if (smod_c >= 6'(BACKOFF_SLOTS)) smod_c = smod_c - 6'(BACKOFF_SLOTS);
    end
  end

  assign prod   = PW'(val0) * PW'(RECIP_1000);
  assign thou_c = MSG_WIDTH'(MSG_WIDTH'(q1) * MSG_WIDTH'(DUR_MOD));
  assign rem_c  = val1 - thou_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept)    v0 <= 1'b1;
      else if (adv0) v0 <= 1'b0;
      if (adv0)      v1 <= 1'b1;
      else if (adv1) v1 <= 1'b0;
      if (adv1)      v2 <= 1'b1;
      else if (take) v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act0   <= action;
      val0   <= MSG_WIDTH'(msg_value);
      slots0 <= backoff_slots;
    end
    if (adv0) begin
      act1  <= act0;
      val1  <= val0;
      q1    <= prod[RECIP_SHIFT +: QW];
      smod1 <= smod_c[SW-1:0];
    end
    if (adv1) begin
      act2  <= act1;
      val2  <= val1;
      thou2 <= thou_c;
      rem2  <= rem_c[REM_W-1:0];
      boff2 <= BOFF_W'(smod1) * BOFF_W'(slot_ticks);
    end
  end

  assign ctrl.valid  = v2;
  assign ctrl.action = act2;
  assign item_value  = val2;
  assign item_rem    = rem2;
  assign item_thou   = thou2;
  assign item_boff   = boff2;

endmodule

FILE: rtl/cca_core.sv
// Mode state machine, countdown timer and result register of the controller.
module cca_core
  import cca_pkg::*;
#(
  parameter int MSG_WIDTH = 24,
  parameter int BOFF_W    = 11
)(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  stage_ctrl_t          ctrl,
  input  logic [MSG_WIDTH-1:0] item_value,
  input  logic [REM_W-1:0]     item_rem,
  input  logic [MSG_WIDTH-1:0] item_thou,
  input  logic [BOFF_W-1:0]    item_boff,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PORT_W-1:0]    out_port,
  output logic [VALUE_W-1:0]   out_value
);

  localparam int SUMW = ((BOFF_W > TICK_W) ? BOFF_W : TICK_W) + 1;

  mode_t                mode, mode_next;
  logic [CNT_W-1:0]     countdown, countdown_next;
  logic                 timer_running, timer_running_next;
  logic [MSG_WIDTH-1:0] pending_msg, pending_msg_next;
  logic [REM_W-1:0]     pending_rem, pending_rem_next;
  logic [MSG_WIDTH-1:0] received_thou, received_thou_next;
  logic [BOFF_W-1:0]    backoff_ticks, backoff_ticks_next;
  logic                 channel_free, channel_free_next;

  logic                 res_hit;
  logic [PORT_W-1:0]    res_port;
  logic [VALUE_W-1:0]   res_value;

  logic [SUMW-1:0]      difs_sum_new, difs_sum_old;
  logic [CNT_W-1:0]     difs_load_new, difs_load_old;
  logic [MSG_WIDTH:0]   pkt_sum;
  logic [MSG_WIDTH-1:0] pkt_sat;
  logic [31:0]          pend_wide, pkt_wide;

  assign take = ctrl.valid && (!out_valid || !out_stall);

  assign difs_sum_new  = SUMW'(cfg.difs) + SUMW'(item_boff);
  assign difs_sum_old  = SUMW'(cfg.difs) + SUMW'(backoff_ticks);
  assign difs_load_new = (32'(difs_sum_new) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(difs_sum_new);
  assign difs_load_old = (32'(difs_sum_old) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(difs_sum_old);

  // Ack packet saturates at the largest message value.
  assign pkt_sum   = (MSG_WIDTH+1)'(cfg.ack) + (MSG_WIDTH+1)'(received_thou);
  assign pkt_sat   = pkt_sum[MSG_WIDTH] ? '1 : pkt_sum[MSG_WIDTH-1:0];
  assign pend_wide = 32'(pending_msg);
  assign pkt_wide  = 32'(pkt_sat);

  always_comb begin
    mode_next          = mode;
    countdown_next     = countdown;
    timer_running_next = timer_running;
    pending_msg_next   = pending_msg;
    pending_rem_next   = pending_rem;
    received_thou_next = received_thou;
    backoff_ticks_next = backoff_ticks;
    channel_free_next  = channel_free;
    res_hit            = 1'b0;
    res_port           = PORT_SEND;
    res_value          = '0;
    if (take) begin
      unique case (ctrl.action)
        ACT_TICK: begin
          if (timer_running) begin
            if (countdown > CNT_W'(1)) begin
              countdown_next = countdown - CNT_W'(1);
            end else begin
              countdown_next     = '0;
              timer_running_next = 1'b0;
              unique case (mode)
                MODE_DIFS: begin
                  res_hit            = 1'b1;
                  res_port           = PORT_SEND;
                  res_value          = pend_wide[VALUE_W-1:0];
                  mode_next          = MODE_TRANSMIT;
                  countdown_next     = CNT_W'(pending_rem);
                  timer_running_next = 1'b1;
                end
                MODE_TRANSMIT: begin
                  res_hit          = 1'b1;
                  res_port         = PORT_SENT;
                  res_value        = pend_wide[VALUE_W-1:0];
                  pending_msg_next = '0;
                  pending_rem_next = '0;
                  mode_next        = MODE_WAIT_ACK;
                end
                MODE_ACK_RCVD: begin
                  res_hit   = 1'b1;
                  res_port  = PORT_DONE;
                  res_value = VALUE_W'(1);
                  mode_next = MODE_IDLE;
                end
                MODE_RECEIVING: begin
                  mode_next          = MODE_SIFS;
                  countdown_next     = CNT_W'(cfg.sifs);
                  timer_running_next = 1'b1;
                end
                MODE_SIFS: begin
                  res_hit            = 1'b1;
                  res_port           = PORT_SEND;
                  res_value          = pkt_wide[VALUE_W-1:0];
                  mode_next          = MODE_SEND_ACK;
                  countdown_next     = CNT_W'(cfg.ack);
                  timer_running_next = 1'b1;
                end
                MODE_SEND_ACK: begin
                  if (pending_msg == '0) begin
                    mode_next = MODE_IDLE;
                  end else begin
                    mode_next          = MODE_DIFS;
                    countdown_next     = difs_load_old;
                    timer_running_next = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ACT_DATA: begin
          pending_msg_next   = item_value;
          pending_rem_next   = item_rem;
          backoff_ticks_next = item_boff;
          if (mode == MODE_IDLE) begin
            if (channel_free) begin
              mode_next          = MODE_DIFS;
              countdown_next     = difs_load_new;
              timer_running_next = 1'b1;
            end else begin
              mode_next          = MODE_WAIT_FREE;
              timer_running_next = 1'b0;
            end
          end
        end
        ACT_RECV: begin
          if (mode == MODE_IDLE || mode == MODE_DIFS) begin
            mode_next          = MODE_RECEIVING;
            received_thou_next = item_thou;
            countdown_next     = CNT_W'(item_rem);
            timer_running_next = 1'b1;
          end else if (mode == MODE_WAIT_ACK) begin
            mode_next          = MODE_ACK_RCVD;
            countdown_next     = CNT_W'(item_rem);
            timer_running_next = 1'b1;
          end
        end
        ACT_FREE: begin
          channel_free_next = 1'b1;
          if (mode == MODE_WAIT_FREE) begin
            mode_next          = MODE_DIFS;
            countdown_next     = difs_load_old;
            timer_running_next = 1'b1;
          end
        end
        ACT_BUSY: begin
          channel_free_next = 1'b0;
          if (mode == MODE_DIFS) begin
            mode_next          = MODE_WAIT_FREE;
            timer_running_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      countdown     <= '0;
      timer_running <= 1'b0;
      pending_msg   <= '0;
      pending_rem   <= '0;
      received_thou <= '0;
      backoff_ticks <= '0;
      channel_free  <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      countdown     <= countdown_next;
      timer_running <= timer_running_next;
      pending_msg   <= pending_msg_next;
      pending_rem   <= pending_rem_next;
      received_thou <= received_thou_next;
      backoff_ticks <= backoff_ticks_next;
      channel_free  <= channel_free_next;
      if (!out_valid || !out_stall) out_valid <= res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (res_hit) begin
      out_port  <= res_port;
      out_value <= res_value;
    end
  end

endmodule

FILE: rtl/cca_checker.sv
// Port-level checker for the CSMA/CA controller and its bind to the top level.
module cca_checker
  import cca_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PORT_W-1:0]  out_port,
  input logic [VALUE_W-1:0] out_value
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_port) && $stable(out_value))
    else $error("result changed while stalled");

  // Only the three defined result ports are ever reported.
  a_port_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_port == PORT_SEND || out_port == PORT_SENT || out_port == PORT_DONE))
    else $error("undefined result port");

  // An exchange-done result always carries the value one.
  a_done_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_port == PORT_DONE |-> out_value == VALUE_W'(1))
    else $error("done result with wrong value");

  // Reset empties the result register and the input pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("controller not empty after reset");

endmodule

bind csma_ca_txrx_controller cca_checker u_cca_checker (.*);

FILE: test/cca_checker.sv
// Checker for the CSMA/CA controller: predicts each input transaction and compares results.
`timescale 1ns / 1ps
module cca_scoreboard
  import cca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ACT_W-1:0]      action,
  input  logic [VALUE_W-1:0]    msg_value,
  input  logic [SLOT_IN_W-1:0]  backoff_slots,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PORT_W-1:0]     out_port,
  input  logic [VALUE_W-1:0]    out_value,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    outstanding,
  output int                    results_seen,
  output int                    fail_count
);

  localparam int                 SLOT_MOD  = 5;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [PORT_W-1:0]  port;
    logic [VALUE_W-1:0] value;
  } frame_t;

  cfg_t               timing;
  mode_t              mode;
  logic [CNT_W-1:0]   countdown;
  logic               running;
  logic [VALUE_W-1:0] queued_msg;
  logic [VALUE_W-1:0] heard_msg;
  logic [10:0]        backoff;
  logic               chan_free;
  frame_t             due_frames[$];
  int                 mismatches = 0;
  int                 matched = 0;

  task automatic load_timer(input int ticks);
    countdown = (ticks > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(ticks);
    running = 1'b1;
  endtask

  task automatic enter_difs();
    mode = MODE_DIFS;
    load_timer(int'(timing.difs) + int'(backoff));
  endtask

  // The mode being left decides whether a frame goes out.
  task automatic expire_timer(output logic hit, output frame_t fr);
    longint ack_pkt;
    hit = 1'b0;
    fr = '0;
    running = 1'b0;
    case (mode)
      MODE_DIFS: begin
        hit = 1'b1;
        fr.port = PORT_SEND;
        fr.value = queued_msg;
        mode = MODE_TRANSMIT;
        load_timer(int'(queued_msg % DUR_MOD));
      end
      MODE_TRANSMIT: begin
        hit = 1'b1;
        fr.port = PORT_SENT;
        fr.value = queued_msg;
        queued_msg = '0;
        mode = MODE_WAIT_ACK;
      end
      MODE_ACK_RCVD: begin
        hit = 1'b1;
        fr.port = PORT_DONE;
        fr.value = VALUE_W'(1);
        mode = MODE_IDLE;
      end
      MODE_RECEIVING: begin
        mode = MODE_SIFS;
        load_timer(int'(timing.sifs));
      end
      MODE_SIFS: begin
        ack_pkt = longint'(timing.ack) + longint'(heard_msg / DUR_MOD) * DUR_MOD;
        if (ack_pkt > longint'(VALUE_MAX)) begin
          ack_pkt = longint'(VALUE_MAX);
        end
        hit = 1'b1;
        fr.port = PORT_SEND;
        fr.value = VALUE_W'(ack_pkt);
        mode = MODE_SEND_ACK;
        load_timer(int'(timing.ack));
      end
      MODE_SEND_ACK: begin
        if (queued_msg == '0) begin
          mode = MODE_IDLE;
        end else begin
          enter_difs();
        end
      end
      default: ;
    endcase
  endtask

  task automatic apply_event(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val,
                             input logic [SLOT_IN_W-1:0] slots,
                             output logic hit, output frame_t fr);
    int lanes;
    hit = 1'b0;
    fr = '0;
    case (act)
      ACT_TICK: begin
        if (running) begin
          if (countdown > 1) begin
            countdown = countdown - 1'b1;
          end else begin
            countdown = '0;
            expire_timer(hit, fr);
          end
        end
      end
      ACT_DATA: begin
        queued_msg = val;
        lanes = int'(slots) % SLOT_MOD;
        backoff = 11'(lanes * int'(timing.slot));
        if (mode == MODE_IDLE) begin
          if (chan_free) begin
            enter_difs();
          end else begin
            mode = MODE_WAIT_FREE;
            running = 1'b0;
          end
        end
      end
      ACT_RECV: begin
        if (mode == MODE_IDLE || mode == MODE_DIFS) begin
          mode = MODE_RECEIVING;
          heard_msg = val;
          load_timer(int'(val % DUR_MOD));
        end else if (mode == MODE_WAIT_ACK) begin
          mode = MODE_ACK_RCVD;
          load_timer(int'(val % DUR_MOD));
        end
      end
      ACT_FREE: begin
        chan_free = 1'b1;
        if (mode == MODE_WAIT_FREE) begin
          enter_difs();
        end
      end
      ACT_BUSY: begin
        chan_free = 1'b0;
        if (mode == MODE_DIFS) begin
          mode = MODE_WAIT_FREE;
          running = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic   hit;
    frame_t fr;
    frame_t want;
    if (rst) begin
      timing.difs = DIFS_RST;
      timing.sifs = SIFS_RST;
      timing.ack = ACK_RST;
      timing.slot = SLOT_RST;
      mode = MODE_IDLE;
      countdown = '0;
      running = 1'b0;
      queued_msg = '0;
      heard_msg = '0;
      backoff = '0;
      chan_free = 1'b1;
      due_frames.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_addr)
          CFG_DIFS: timing.difs = cfg_wdata;
          CFG_SIFS: timing.sifs = cfg_wdata;
          CFG_ACK:  timing.ack = cfg_wdata;
          CFG_SLOT: timing.slot = cfg_wdata[SLOT_W-1:0];
          default: ;
        endcase
      end
      // A result can never belong to an input taken at the same edge.
      if (out_valid && !out_stall) begin
        if (due_frames.size() == 0) begin
          $error("unexpected result: out_port %0d, out_value %0d", out_port, out_value);
          mismatches++;
        end else begin
          want = due_frames.pop_front();
          matched++;
          if (out_port !== want.port) begin
            $error("out_port: expected %0d, actual %0d", want.port, out_port);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, out_value);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_event(action, msg_value, backoff_slots, hit, fr);
        if (hit) begin
          due_frames.push_back(fr);
        end
      end
    end
    outstanding <= due_frames.size();
    results_seen <= matched;
    fail_count <= mismatches;
  end

endmodule

FILE: test/testbench.sv
// Top of the CSMA/CA controller testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import cca_pkg::*;

  // Percentage of cycles in which either side holds back.
  localparam int STALL_PCT      = 21;
  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last expected result for the pipeline to drain.
  localparam int DRAIN_CYCLES   = 12;
  // Action codes above the last defined one are ignored by the block.
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_BUSY + 1'b1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;
  localparam int               THOUSANDS_MAX = (2 ** VALUE_W - 1) / DUR_MOD;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACT_W-1:0]      action = ACT_TICK;
  logic [VALUE_W-1:0]    msg_value = '0;
  logic [SLOT_IN_W-1:0]  backoff_slots = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PORT_W-1:0]     out_port;
  logic [VALUE_W-1:0]    out_value;
  logic                  cfg_wr = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DIFS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // While quiet is set the result side never stalls, so the pipeline can
  // empty out before the timing registers are rewritten.
  logic quiet = 1'b1;
  // While calm is set neither side idles at all.
  logic calm = 1'b0;

  int outstanding;
  int results_seen;
  int fail_count;
  int stuck_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  csma_ca_txrx_controller dut (.*);

  // The checker watches every channel, keeps its own copy of the controller
  // state and hands back the number of failures it found.
  cca_scoreboard watcher (.*);

  // The result side stalls at random, except in quiet and calm stretches.
  always @(posedge clk) begin
    if (rst || quiet || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // Watchdog: counts cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Message values are mostly a random thousands part with a short duration
  // in the low digits, so that timed modes end within a handful of ticks.
  // A few are fully random or sit at the ends of the range.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      return VALUE_W'($urandom);
    end
    if (r < 12) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return VALUE_MAX;
        2: return VALUE_W'(THOUSANDS_MAX * DUR_MOD + $urandom_range(0, 3));
        default: return VALUE_W'($urandom_range(0, 9));
      endcase
    end
    return VALUE_W'($urandom_range(0, THOUSANDS_MAX) * DUR_MOD + $urandom_range(0, 6));
  endfunction

  // Slot counts above the legal range are folded by the block, so they
  // appear now and then too.
  function automatic logic [SLOT_IN_W-1:0] pick_slots();
    if ($urandom_range(0, 99) < 85) begin
      return SLOT_IN_W'($urandom_range(0, 4));
    end
    return SLOT_IN_W'($urandom_range(5, 7));
  endfunction

  // Ticks dominate so that countdowns actually run out; the rest is a mix of
  // channel events with a little noise from undefined action codes.
  function automatic logic [ACT_W-1:0] pick_action(input int tick_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      return ACT_TICK;
    end
    r = $urandom_range(0, 99);
    if (r < 25) begin
      return ACT_DATA;
    end
    if (r < 50) begin
      return ACT_RECV;
    end
    if (r < 70) begin
      return ACT_FREE;
    end
    if (r < 90) begin
      return ACT_BUSY;
    end
    return ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
  endfunction

  // Offers one input transaction and returns at the edge that accepts it.
  // Valid is left high on return; the next call or settle decides whether
  // it drops, so it is never lowered and raised within one time step.
  task automatic push_event(input logic [ACT_W-1:0] act, input logic [VALUE_W-1:0] val,
                            input logic [SLOT_IN_W-1:0] slots);
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    msg_value <= val;
    backoff_slots <= slots;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Writes all four timing registers; only called while the block is idle.
  task automatic write_timing(input logic [TICK_W-1:0] difs, sifs, ack,
                              input logic [SLOT_W-1:0] slot);
    cfg_wr <= 1'b1;
    cfg_addr <= CFG_DIFS;
    cfg_wdata <= difs;
    @(posedge clk);
    cfg_addr <= CFG_SIFS;
    cfg_wdata <= sifs;
    @(posedge clk);
    cfg_addr <= CFG_ACK;
    cfg_wdata <= ack;
    @(posedge clk);
    cfg_addr <= CFG_SLOT;
    cfg_wdata <= CFG_DATA_W'(slot);
    @(posedge clk);
    cfg_wr <= 1'b0;
    quiet <= 1'b0;
  endtask

  // Stops input, lets every expected result arrive, then waits out the
  // pipeline so that transactions without a result are finished as well.
  task automatic settle();
    in_valid <= 1'b0;
    quiet <= 1'b1;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random phase under one timing setting. Undefined actions are noise
  // and do not count toward the phase length. A phase may keep going until
  // a given number of results has come back, within a generous bound.
  task automatic run_phase(input logic [TICK_W-1:0] difs, sifs, ack,
                           input logic [SLOT_W-1:0] slot, input int items,
                           input int tick_pct, input logic steady, input int want_results);
    int               count;
    logic [ACT_W-1:0] act;
    count = 0;
    write_timing(difs, sifs, ack, slot);
    calm = steady;
    while (count < items || (results_seen < want_results && count < 4 * items)) begin
      act = pick_action(tick_pct);
      push_event(act, pick_value(), pick_slots());
      if (act <= ACT_BUSY) begin
        count++;
      end
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part with short timings: no DIFS, a one-tick SIFS, one tick
    // per slot, and an ack time large enough to overflow the ack packet.
    write_timing(10'd0, 10'd1, 10'd250, 8'd1);
    // A tick with no timer running and undefined actions change nothing.
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_UNUSED_LO, VALUE_MAX, '1);
    push_event(ACT_UNUSED_HI, '0, '0);
    // Data while the channel is busy waits for it to free up; the slot
    // count is out of range and folds back.
    push_event(ACT_BUSY, '0, '0);
    push_event(ACT_DATA, VALUE_W'(THOUSANDS_MAX * DUR_MOD), 3'd7);
    // A frame received in that mode is ignored, and so is a tick.
    push_event(ACT_RECV, VALUE_W'(1), '0);
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_FREE, '0, '0);
    // New data during DIFS replaces the message and its backoff only.
    push_event(ACT_DATA, VALUE_W'(2001), 3'd4);
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_TICK, '0, '0);
    // A frame received during transmit is ignored.
    push_event(ACT_RECV, VALUE_W'(5), '0);
    push_event(ACT_TICK, '0, '0);
    // Data while waiting for the ack, then the ack with a zero duration.
    push_event(ACT_DATA, '0, '0);
    push_event(ACT_RECV, VALUE_W'(1000), '0);
    push_event(ACT_TICK, '0, '0);
    // A zero message is sent like any other; busy during DIFS suspends it.
    push_event(ACT_DATA, '0, '0);
    push_event(ACT_BUSY, '0, '0);
    push_event(ACT_FREE, '0, '0);
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_RECV, VALUE_W'(THOUSANDS_MAX * DUR_MOD), '0);
    push_event(ACT_TICK, '0, '0);
    // A frame received during DIFS preempts the send; its ack packet
    // overflows and saturates, and the pending data restarts DIFS later.
    push_event(ACT_DATA, VALUE_W'(999), 3'd1);
    push_event(ACT_RECV, VALUE_W'(THOUSANDS_MAX * DUR_MOD), '0);
    push_event(ACT_TICK, '0, '0);
    push_event(ACT_TICK, '0, '0);
    settle();

    // Random phases: the reset timings, all zero, all but the ack at their maximum,
    // a long ack with no idling on either side, and short timings to finish.
    run_phase(10'd50, 10'd20, 10'd10, 8'd5, 300, 75, 1'b0, 0);
    run_phase(10'd0, 10'd0, 10'd0, 8'd0, 250, 70, 1'b0, 0);
    run_phase(10'd1023, 10'd1023, 10'd999, 8'd255, 150, 92, 1'b0, 0);
    run_phase(10'd1, 10'd0, 10'd300, 8'd2, 350, 75, 1'b1, 0);
    run_phase(10'd3, 10'd2, 10'd1, 8'd1, 400, 70, 1'b0, 60);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
